// ----- src/f2i8_pkg.sv -----
// ----------------------------------------------------------------------------
// f2i8_pkg
// Shared types and constants for the float-to-int8 power-of-two quantizer.
// ----------------------------------------------------------------------------
package f2i8_pkg;

  localparam int FloatW = 32;
  localparam int OutW   = 8;
  localparam int SigW   = 24;

  localparam logic [7:0] ExpMax  = 8'hFF;
  localparam logic [7:0] ExpZero = 8'h00;
  // bias plus mantissa width: value = sig * 2^(expo - 150)
  localparam logic signed [10:0] ExpOffset = 11'sd150;
  localparam logic signed [10:0] MaxShift  = 11'sd25;

  localparam logic signed [OutW-1:0] SatPos = 8'sd127;
  localparam logic signed [OutW-1:0] SatNeg = -8'sd128;

  // decoded fields of one float beat
  typedef struct packed {
    logic              sign;
    logic              is_nan;
    logic              is_inf;
    logic              is_zero;
    logic signed [10:0] sh;
    logic [SigW-1:0]   sig;
  } f2i8_dec_t;

endpackage

// ----- src/f2i8_round.sv -----
// ----------------------------------------------------------------------------
// f2i8_round
// Combinational scale, round-to-nearest (ties up) and saturation to int8.
// ----------------------------------------------------------------------------
module f2i8_round (
  input  logic [f2i8_pkg::FloatW-1:0]        float_in,
  input  logic signed [7:0]                  fix_position,
  output logic signed [f2i8_pkg::OutW-1:0]   fixed_value
);
  import f2i8_pkg::*;

  f2i8_dec_t   dec;
  logic [4:0]  n;
  logic [SigW-1:0] q;
  // one bit wider than sig so the half bit still exists at the largest shift
  logic [SigW:0] r;
  logic [SigW:0] half;
  logic [8:0]  mag;
  logic        up;

  // decode fields and apply scale as exponent offset
  always_comb begin
    dec.sign    = float_in[31];
    dec.is_nan  = (float_in[30:23] == ExpMax) && (float_in[22:0] != '0);
    dec.is_inf  = (float_in[30:23] == ExpMax) && (float_in[22:0] == '0);
    dec.is_zero = (float_in[30:23] == ExpZero);
    dec.sig     = {1'b1, float_in[22:0]};
    dec.sh      = $signed({3'b000, float_in[30:23]}) - ExpOffset
                  + $signed({{3{fix_position[7]}}, fix_position});
  end

  // shift, round and saturate
  always_comb begin
    n    = 5'(-dec.sh);
    q    = dec.sig >> n;
    r    = {1'b0, dec.sig} & (((SigW+1)'(1) << n) - (SigW+1)'(1));
    half = (SigW+1)'(1) << (n - 5'd1);
    up   = dec.sign ? (r > half) : (r >= half);
    mag  = 9'(q[7:0]) + 9'(up);
    if (dec.is_nan || dec.is_zero) begin
      fixed_value = '0;
    end else if (dec.is_inf || dec.sh >= 0) begin
      fixed_value = dec.sign ? SatNeg : SatPos;
    end else if (dec.sh < -MaxShift) begin
      fixed_value = '0;
    end else if (!dec.sign) begin
      fixed_value = (q > 24'd127 || mag > 9'd127) ? SatPos : OutW'(mag);
    end else begin
      fixed_value = (q > 24'd128 || mag > 9'd128) ? SatNeg : OutW'(-mag);
    end
  end

endmodule

// ----- src/float_to_int8_pow2_quantize.sv -----
// ----------------------------------------------------------------------------
// float_to_int8_pow2_quantize
// Quantizes float32 beats to int8 with a power-of-two scale.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready carry float_in, one float32 per beat.
//   out channel : out_valid/out_ready carry fixed_value, one int8 per beat.
//   cfg channel : cfg_valid/cfg_ready write fix_position (signed 8 bit),
//                 the scale exponent; write only while the block is idle.
// Path: an accepted beat is captured in the input register, converted
//   by one stage of logic and shown from the result register.
// Throughput: one beat per cycle; both stages advance together whenever
//   the result register is free or is taken in the same cycle.
// Stall: when out_ready is low a valid result holds, an empty input register
//   can still take a beat, and in_ready drops once both stages are full.
// Reset: both stages empty, fix_position returns to 0.
// ----------------------------------------------------------------------------
module float_to_int8_pow2_quantize (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [f2i8_pkg::FloatW-1:0]       float_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [f2i8_pkg::OutW-1:0]  fixed_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [7:0]                 fix_position
);
  import f2i8_pkg::*;

  logic signed [7:0]     fix_reg;
  logic [FloatW-1:0]     in_data;
  logic                  in_full;
  logic signed [OutW-1:0] res_next;
  logic                  advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_full || advance;

  // hold scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_reg <= '0;
    end else if (cfg_valid) begin
      fix_reg <= fix_position;
    end
  end

  // capture input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= float_in;
    end
  end

  f2i8_round u_round (
    .float_in     (in_data),
    .fix_position (fix_reg),
    .fixed_value  (res_next)
  );

  // advance result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      fixed_value <= res_next;
    end
  end

  // a stalled result must hold its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fixed_value))
    else $error("result changed under stall");

  // a full input stage moves on whenever the output frees
  a_in_moves: assert property (@(posedge clk) disable iff (rst)
    in_full && advance |=> out_valid)
    else $error("input stage did not advance");

  // input stage may only block while the result is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input blocked without stall");

endmodule
